### hw/rtl/mgcfd_pkg.sv
// Shared types, codes and the field layout table of the frame decoder.
`timescale 1ns / 1ps
package mgcfd_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 64;

    localparam logic [7:0] SYNC_0    = 8'h55;
    localparam logic [7:0] SYNC_1    = 8'hAA;
    localparam logic [7:0] ID_GPS    = 8'h10;
    localparam logic [7:0] LEN_GPS   = 8'h3A;
    localparam logic [7:0] ID_CMP    = 8'h20;
    localparam logic [7:0] LEN_CMP   = 8'h06;
    localparam logic [5:0] ADDR_GPS_MASK = 6'd55;
    localparam logic [5:0] ADDR_CMP_MASK = 6'd4;

    localparam logic       MSG_GPS = 1'b0;
    localparam logic       MSG_CMP = 1'b1;

    localparam logic [7:0] FIX_TYPE_2D = 8'h02;
    localparam logic [7:0] FIX_TYPE_3D = 8'h03;
    localparam logic [1:0] FIX_NONE = 2'd0;
    localparam logic [1:0] FIX_2D   = 2'd1;
    localparam logic [1:0] FIX_3D   = 2'd2;
    localparam logic [1:0] FIX_DIFF = 2'd3;

    typedef enum logic [3:0] {
        ST_HDR0, ST_HDR1, ST_ID, ST_LEN, ST_PAY, ST_CKA, ST_CKB,
        ST_MASK_RD, ST_MASK_CAP, ST_FETCH, ST_CAPT, ST_FORMAT
    } t_state;

    typedef enum logic [3:0] {
        K_SEC, K_MIN, K_HOUR, K_DAY, K_MONTH, K_YEAR, K_W32, K_H16,
        K_RAW8, K_FIX, K_MAGX, K_MAGY, K_CX, K_CY
    } t_kind;

    typedef struct packed {
        logic [5:0] addr;
        logic [2:0] nbytes;
        t_kind      kind;
        logic       last;
    } t_fdesc;

    typedef struct packed {
        logic clr_sum;
        logic take_id;
        logic take_len;
        logic take_pay;
        logic start_emit;
        logic mask_rd;
        logic mask_cap;
        logic fetch_cap;
        logic next_field;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_sync0;
        logic is_sync1;
        logic len_ok;
        logic pay_done;
        logic cka_ok;
        logic ckb_ok;
        logic no_bytes;
        logic byte_last;
        logic field_last;
        logic out_free;
    } t_status;

    // Where each output field lives in the payload and how it is formed.
    function automatic t_fdesc field_desc(input logic typ, input logic [4:0] idx);
        t_fdesc d;
        d = '{addr: 6'd0, nbytes: 3'd0, kind: K_CY, last: 1'b0};
        if (typ == MSG_GPS) begin
            unique case (idx)
                5'd0:  d = '{6'd0,  3'd4, K_SEC,   1'b0};
                5'd1:  d = '{6'd0,  3'd4, K_MIN,   1'b0};
                5'd2:  d = '{6'd0,  3'd4, K_HOUR,  1'b0};
                5'd3:  d = '{6'd0,  3'd4, K_DAY,   1'b0};
                5'd4:  d = '{6'd0,  3'd4, K_MONTH, 1'b0};
                5'd5:  d = '{6'd0,  3'd4, K_YEAR,  1'b0};
                5'd6:  d = '{6'd4,  3'd4, K_W32,   1'b0};
                5'd7:  d = '{6'd8,  3'd4, K_W32,   1'b0};
                5'd8:  d = '{6'd12, 3'd4, K_W32,   1'b0};
                5'd9:  d = '{6'd28, 3'd4, K_W32,   1'b0};
                5'd10: d = '{6'd32, 3'd4, K_W32,   1'b0};
                5'd11: d = '{6'd36, 3'd4, K_W32,   1'b0};
                5'd12: d = '{6'd42, 3'd2, K_H16,   1'b0};
                5'd13: d = '{6'd44, 3'd2, K_H16,   1'b0};
                5'd14: d = '{6'd46, 3'd2, K_H16,   1'b0};
                5'd15: d = '{6'd48, 3'd1, K_RAW8,  1'b0};
                5'd16: d = '{6'd50, 3'd4, K_FIX,   1'b1};
                default: d = '{6'd50, 3'd4, K_FIX, 1'b1};
            endcase
        end else begin
            unique case (idx)
                5'd0:    d = '{6'd0, 3'd2, K_MAGX, 1'b0};
                5'd1:    d = '{6'd2, 3'd2, K_MAGY, 1'b0};
                5'd2:    d = '{6'd0, 3'd0, K_CX,   1'b0};
                default: d = '{6'd0, 3'd0, K_CY,   1'b1};
            endcase
        end
        return d;
    endfunction

endpackage

### hw/rtl/mgcfd_datapath.sv
// Datapath: checksums, payload memory, field assembly, calibration and output register.
`timescale 1ns / 1ps
module mgcfd_datapath
    import mgcfd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_rx_byte,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_msg_type,
    output logic [4:0]         o_field_index,
    output logic signed [31:0] o_field_value,
    output logic               o_last_field
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic [7:0]  r_mem [PAYLOAD_DEPTH];
    logic [7:0]  r_rdata;
    logic [AW-1:0] rd_addr;

    logic [7:0]  r_id;
    logic [5:0]  r_len;
    logic [5:0]  r_count;
    logic [7:0]  r_sum_a;
    logic [7:0]  r_sum_b;
    logic [7:0]  n_sum_a;

    logic        r_type;
    logic [4:0]  r_field;
    logic [1:0]  r_k;
    logic [7:0]  r_mask;
    logic [31:0] r_acc;
    t_fdesc      desc;

    logic signed [15:0] r_x_high, r_x_low, r_y_high, r_y_low;
    logic signed [15:0] r_x, r_y;
    logic signed [15:0] cur16;
    logic signed [15:0] n_x_high, n_x_low, n_y_high, n_y_low;
    logic signed [16:0] centre_sum;
    logic signed [16:0] centre;
    logic signed [16:0] centred;

    logic [7:0]  cmp_mask;
    logic [5:0]  day;
    logic [1:0]  fix;
    logic [31:0] value;

    logic        r_out_valid;

    assign desc = field_desc(r_type, r_field);
    assign n_sum_a = r_sum_a + i_rx_byte;
    assign rd_addr = i_cmd.mask_rd ?
                     AW'((r_type == MSG_CMP) ? ADDR_CMP_MASK : ADDR_GPS_MASK) :
                     AW'(desc.addr + {4'd0, r_k});

    // Compass mask: nibbles of the key byte shuffled, with its low bit spread.
    assign cmp_mask = {r_rdata[4:1] ^ {r_rdata[0], 3'b000},
                       (r_rdata[3:0] ^ r_rdata[7:4]) ^ {r_rdata[0], 3'b000}};

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pay && (r_count < PAYLOAD_DEPTH)) begin
            r_mem[AW'(r_count)] <= i_rx_byte;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id    <= 8'd0;
            r_len   <= 6'd0;
            r_count <= 6'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
        end else begin
            if (i_cmd.clr_sum) begin
                r_sum_a <= 8'd0;
                r_sum_b <= 8'd0;
            end
            if (i_cmd.take_id || i_cmd.take_len || i_cmd.take_pay) begin
                r_sum_a <= n_sum_a;
                r_sum_b <= r_sum_b + n_sum_a;
            end
            if (i_cmd.take_id) begin
                r_id <= i_rx_byte;
            end
            if (i_cmd.take_len) begin
                r_len   <= i_rx_byte[5:0];
                r_count <= 6'd0;
            end
            if (i_cmd.take_pay) begin
                r_count <= r_count + 6'd1;
            end
        end
    end

    // Field sequencing and byte assembly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= MSG_GPS;
            r_field <= 5'd0;
            r_k     <= 2'd0;
        end else begin
            if (i_cmd.start_emit) begin
                r_type <= (r_id == ID_CMP) ? MSG_CMP : MSG_GPS;
            end
            if (i_cmd.mask_cap) begin
                r_field <= 5'd0;
                r_k     <= 2'd0;
            end
            if (i_cmd.fetch_cap) begin
                r_k <= r_k + 2'd1;
            end
            if (i_cmd.next_field) begin
                r_field <= r_field + 5'd1;
                r_k     <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mask_cap) begin
            r_mask <= (r_type == MSG_CMP) ? cmp_mask : r_rdata;
        end
        if (i_cmd.fetch_cap) begin
            r_acc[8*r_k +: 8] <= r_rdata ^ r_mask;
        end
    end

    assign cur16 = r_acc[15:0];
    assign n_x_high = (cur16 > r_x_high) ? cur16 : r_x_high;
    assign n_x_low  = (cur16 < r_x_low)  ? cur16 : r_x_low;
    assign n_y_high = (cur16 > r_y_high) ? cur16 : r_y_high;
    assign n_y_low  = (cur16 < r_y_low)  ? cur16 : r_y_low;

    // Centre is the midpoint truncated toward zero, so negative sums round up.
    always_comb begin
        if (desc.kind == K_CX) begin
            centre_sum = 17'(r_x_high) + 17'(r_x_low);
        end else begin
            centre_sum = 17'(r_y_high) + 17'(r_y_low);
        end
        centre = (centre_sum + $signed({16'd0, centre_sum[16]})) >>> 1;
        if (desc.kind == K_CX) begin
            centred = 17'(r_x) - centre;
        end else begin
            centred = 17'(r_y) - centre;
        end
    end

    assign day = {1'b0, r_acc[20:16]} + {5'd0, (r_acc[15:12] > 4'd7)};

    always_comb begin
        if (r_acc[7:0] == FIX_TYPE_2D) begin
            fix = FIX_2D;
        end else if (r_acc[7:0] == FIX_TYPE_3D) begin
            fix = FIX_3D;
        end else begin
            fix = FIX_NONE;
        end
        if ((fix != FIX_NONE) && r_acc[17]) begin
            fix = FIX_DIFF;
        end
    end

    always_comb begin
        unique case (desc.kind)
            K_SEC:   value = {26'd0, r_acc[5:0]};
            K_MIN:   value = {26'd0, r_acc[11:6]};
            K_HOUR:  value = {28'd0, r_acc[15:12]};
            K_DAY:   value = {26'd0, day};
            K_MONTH: value = {28'd0, r_acc[24:21]};
            K_YEAR:  value = {25'd0, r_acc[31:25]};
            K_W32:   value = r_acc;
            K_H16,
            K_MAGX,
            K_MAGY:  value = {{16{r_acc[15]}}, r_acc[15:0]};
            K_RAW8:  value = {24'd0, r_acc[7:0] ^ r_mask};
            K_FIX:   value = {30'd0, fix};
            K_CX,
            K_CY:    value = {{15{centred[16]}}, centred};
            default: value = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_high <= 16'sd0;
            r_x_low  <= 16'sd0;
            r_y_high <= 16'sd0;
            r_y_low  <= 16'sd0;
        end else if (i_cmd.load_out) begin
            if (desc.kind == K_MAGX) begin
                r_x_high <= n_x_high;
                r_x_low  <= n_x_low;
            end
            if (desc.kind == K_MAGY) begin
                r_y_high <= n_y_high;
                r_y_low  <= n_y_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out && (desc.kind == K_MAGX)) begin
            r_x <= cur16;
        end
        if (i_cmd.load_out && (desc.kind == K_MAGY)) begin
            r_y <= cur16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_msg_type    <= r_type;
            o_field_index <= r_field;
            o_field_value <= value;
            o_last_field  <= desc.last;
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_status.is_sync0   = (i_rx_byte == SYNC_0);
        o_status.is_sync1   = (i_rx_byte == SYNC_1);
        o_status.len_ok     = ((r_id == ID_GPS) && (i_rx_byte == LEN_GPS)) ||
                              ((r_id == ID_CMP) && (i_rx_byte == LEN_CMP));
        o_status.pay_done   = ({1'b0, r_count} + 7'd1) >= {1'b0, r_len};
        o_status.cka_ok     = (i_rx_byte == r_sum_a);
        o_status.ckb_ok     = (i_rx_byte == r_sum_b);
        o_status.no_bytes   = (desc.nbytes == 3'd0);
        o_status.byte_last  = ({1'b0, r_k} == (desc.nbytes - 3'd1));
        o_status.field_last = desc.last;
        o_status.out_free   = !r_out_valid || i_ready;
    end

endmodule

### hw/rtl/mgcfd_ctrl.sv
// Controller: frame parsing state machine and result sequencing.
`timescale 1ns / 1ps
module mgcfd_ctrl
    import mgcfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   in_acc;

    assign o_ready = (r_state == ST_HDR0) || (r_state == ST_HDR1) || (r_state == ST_ID) ||
                     (r_state == ST_LEN)  || (r_state == ST_PAY)  || (r_state == ST_CKA) ||
                     (r_state == ST_CKB);
    assign in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_HDR0: if (in_acc) begin
                n_state = i_status.is_sync0 ? ST_HDR1 : ST_HDR0;
            end
            ST_HDR1: if (in_acc) begin
                n_state = i_status.is_sync1 ? ST_ID : ST_HDR0;
            end
            ST_ID: if (in_acc) begin
                n_state = ST_LEN;
            end
            ST_LEN: if (in_acc) begin
                n_state = i_status.len_ok ? ST_PAY : ST_HDR0;
            end
            ST_PAY: if (in_acc && i_status.pay_done) begin
                n_state = ST_CKA;
            end
            ST_CKA: if (in_acc) begin
                n_state = i_status.cka_ok ? ST_CKB : ST_HDR0;
            end
            ST_CKB: if (in_acc) begin
                n_state = i_status.ckb_ok ? ST_MASK_RD : ST_HDR0;
            end
            ST_MASK_RD:  n_state = ST_MASK_CAP;
            ST_MASK_CAP: n_state = ST_FETCH;
            ST_FETCH:    n_state = i_status.no_bytes ? ST_FORMAT : ST_CAPT;
            ST_CAPT:     n_state = i_status.byte_last ? ST_FORMAT : ST_FETCH;
            ST_FORMAT: if (i_status.out_free) begin
                n_state = i_status.field_last ? ST_HDR0 : ST_FETCH;
            end
            default: n_state = ST_HDR0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_HDR1:     o_cmd.clr_sum    = in_acc && i_status.is_sync1;
            ST_ID:       o_cmd.take_id    = in_acc;
            ST_LEN:      o_cmd.take_len   = in_acc && i_status.len_ok;
            ST_PAY:      o_cmd.take_pay   = in_acc;
            ST_CKB:      o_cmd.start_emit = in_acc && i_status.ckb_ok;
            ST_MASK_RD:  o_cmd.mask_rd    = 1'b1;
            ST_MASK_CAP: o_cmd.mask_cap   = 1'b1;
            ST_CAPT:     o_cmd.fetch_cap  = 1'b1;
            ST_FORMAT: begin
                o_cmd.load_out   = i_status.out_free;
                o_cmd.next_field = i_status.out_free && !i_status.field_last;
            end
            default: ;
        endcase
    end

endmodule

### hw/rtl/masked_gps_compass_frame_decoder.sv
// Top level of the masked GPS and compass frame decoder.
//
// Input channel: one received byte per request on i_rx_byte, taken when
// i_valid and o_ready are both high. Bytes are parsed as sync 0x55 0xAA,
// id, length, payload and two running-sum check bytes. Each byte of the
// stream is taken as soon as it is offered while a frame is being parsed.
// Output channel: one decoded field per request (o_msg_type,
// o_field_index, o_field_value, o_last_field), taken on o_valid and i_ready.
// A verified GPS frame gives 17 fields, a compass frame 4, the last marked.
// After the second check byte the input is held off while the fields are
// read back from the payload memory: the mask is read and then captured,
// then for each field every stored byte is fetched and captured in turn and
// the output register is loaded; a field with no stored byte goes straight
// from fetch to load without capturing any byte.
// A stalled receiver holds the sequencer on the waiting field; once the
// final field is loaded, input is taken again while it waits. Reset returns
// the parser to hunting for sync and clears the calibration extremes; the
// payload memory is not cleared.
`timescale 1ns / 1ps
module masked_gps_compass_frame_decoder
    import mgcfd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_msg_type,
    output logic [4:0]         o_field_index,
    output logic signed [31:0] o_field_value,
    output logic               o_last_field
);

    t_cmd    cmd;
    t_status status;

    mgcfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mgcfd_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_msg_type    (o_msg_type),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_last_field  (o_last_field)
    );

endmodule
